FILE: rtl/power_energy_meter_unit_defines.svh
// assertion macros shared by the power energy meter modules
`ifndef POWER_ENERGY_METER_UNIT_DEFINES_SVH
`define POWER_ENERGY_METER_UNIT_DEFINES_SVH

// clocked check that is switched off while reset is high
`define PEM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define PEM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pem_pkg.sv
// types and constants of the power energy meter
package pem_pkg;

   localparam int CUR_W      = 15;
   localparam int TIME_W     = 32;
   localparam int VOLT_W     = 9;
   localparam int LIMIT_W    = 15;
   localparam int HOLD_W     = 16;
   localparam int POWER_W    = 24;
   localparam int PROD_W     = 56;
   localparam int ENERGY_W   = 64;
   localparam int PAGE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [VOLT_W-1:0]  SUPPLY_VOLTAGE_RST = VOLT_W'(230);
   localparam logic [LIMIT_W-1:0] OVERLOAD_LIMIT_RST = LIMIT_W'(4000);
   localparam logic [LIMIT_W-1:0] NOISE_FLOOR_RST    = LIMIT_W'(90);
   localparam logic [HOLD_W-1:0]  PAGE_HOLD_RST      = HOLD_W'(3000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPPLY_VOLTAGE = 2'd0,
      CSR_OVERLOAD_LIMIT = 2'd1,
      CSR_NOISE_FLOOR    = 2'd2,
      CSR_PAGE_HOLD      = 2'd3
   } csr_index_type;

   typedef enum logic [PAGE_W-1:0] {
      PAGE_POWER   = 2'd0,
      PAGE_CURRENT = 2'd1,
      PAGE_ENERGY  = 2'd2
   } page_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_POWER  = 2'd1,
      ST_ENERGY = 2'd2,
      ST_ACCUM  = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic power;
      logic energy;
      logic finish;
   } cmd_type;

   function automatic page_type next_page(page_type cur);
      page_type nxt;
      case (cur)
         PAGE_POWER:   nxt = PAGE_CURRENT;
         PAGE_CURRENT: nxt = PAGE_ENERGY;
         default:      nxt = PAGE_POWER;
      endcase
      return nxt;
   endfunction

endpackage

FILE: rtl/pem_channels.sv
// handshake channels of the power energy meter

interface pem_req_if;
   import pem_pkg::*;
   logic              valid;
   logic              ready;
   logic [CUR_W-1:0]  current_ma;
   logic [TIME_W-1:0] time_ms;

   modport source (output valid, output current_ma, output time_ms, input ready);
   modport sink   (input valid, input current_ma, input time_ms, output ready);
endinterface

interface pem_rsp_if;
   import pem_pkg::*;
   logic                valid;
   logic                ready;
   logic [CUR_W-1:0]    clean_current_ma;
   logic [POWER_W-1:0]  power_mw;
   logic [ENERGY_W-1:0] energy_uj;
   logic                green_on;
   logic                red_on;
   logic [PAGE_W-1:0]   display_page;
   logic                page_changed;

   modport source (output valid, output clean_current_ma, output power_mw,
                   output energy_uj, output green_on, output red_on,
                   output display_page, output page_changed, input ready);
   modport sink   (input valid, input clean_current_ma, input power_mw,
                   input energy_uj, input green_on, input red_on,
                   input display_page, input page_changed, output ready);
endinterface

FILE: rtl/pem_ctrl.sv
// sequencer of the power energy meter: handshakes and datapath commands
`include "power_energy_meter_unit_defines.svh"

module pem_ctrl
   import pem_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_POWER;
            end
         end
         ST_POWER: begin
            cmd.power = 1'b1;
            state_in  = ST_ENERGY;
         end
         ST_ENERGY: begin
            cmd.energy = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            // commit state and load the output word once the slot is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PEM_ASSERT(a_accept_starts_work, clock, reset,
      (req_valid && req_ready) |=> (state_ff == ST_POWER), "accepted word did not start work")
   `PEM_ASSERT(a_finish_shows_word, clock, reset,
      (state_ff == ST_ACCUM && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE),
      "finished word not presented")
   `PEM_ASSERT(a_power_then_energy, clock, reset,
      (state_ff == ST_POWER) |=> (state_ff == ST_ENERGY), "power step not followed by energy")

endmodule

FILE: rtl/pem_datapath.sv
// datapath of the power energy meter: settings, running state, multiplies, output word
`include "power_energy_meter_unit_defines.svh"

module pem_datapath
   import pem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [CUR_W-1:0]      in_current_ma,
   input  logic [TIME_W-1:0]     in_time_ms,
   output logic [CUR_W-1:0]      out_clean_current_ma,
   output logic [POWER_W-1:0]    out_power_mw,
   output logic [ENERGY_W-1:0]   out_energy_uj,
   output logic                  out_green_on,
   output logic                  out_red_on,
   output logic [PAGE_W-1:0]     out_display_page,
   output logic                  out_page_changed
);

   // settings
   logic [VOLT_W-1:0]  volt_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] floor_ff;
   logic [HOLD_W-1:0]  hold_ff;

   // running state
   logic [TIME_W-1:0]   last_time_ff;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   page_type            page_ff, page_in;
   logic [TIME_W-1:0]   page_start_ff;
   logic                changed_ff, changed_in;

   // per-word work registers
   logic [CUR_W-1:0]   cur_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [CUR_W-1:0]   clean_ff, clean_in;
   logic               green_ff;
   logic [POWER_W-1:0] power_ff;
   logic [TIME_W-1:0]  dt_ff;
   logic               skip_ff;
   logic [PROD_W-1:0]  prod_ff;

   // output word
   logic [CUR_W-1:0]    o_clean_ff;
   logic [POWER_W-1:0]  o_power_ff;
   logic [ENERGY_W-1:0] o_energy_ff;
   logic                o_green_ff;
   logic [PAGE_W-1:0]   o_page_ff;
   logic                o_changed_ff;

   logic [TIME_W-1:0]   page_elapsed;
   logic                rotate;
   logic [ENERGY_W:0]   sum;

   assign clean_in     = (cur_ff < floor_ff) ? '0 : cur_ff;
   assign page_elapsed = now_ff - page_start_ff;
   assign rotate       = page_elapsed >= TIME_W'(hold_ff);
   assign page_in      = rotate ? next_page(page_ff) : page_ff;
   assign changed_in   = rotate;

   // saturating add, a skipped interval leaves the total as it is
   assign sum = {1'b0, energy_ff} + (ENERGY_W + 1)'(prod_ff);
   always_comb begin
      if (skip_ff) begin
         energy_in = energy_ff;
      end else if (sum[ENERGY_W]) begin
         energy_in = '1;
      end else begin
         energy_in = sum[ENERGY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_ff       <= SUPPLY_VOLTAGE_RST;
         limit_ff      <= OVERLOAD_LIMIT_RST;
         floor_ff      <= NOISE_FLOOR_RST;
         hold_ff       <= PAGE_HOLD_RST;
         last_time_ff  <= '0;
         energy_ff     <= '0;
         page_ff       <= PAGE_POWER;
         page_start_ff <= '0;
         changed_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_SUPPLY_VOLTAGE: volt_ff  <= csr_wdata[VOLT_W-1:0];
               CSR_OVERLOAD_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
               CSR_NOISE_FLOOR:    floor_ff <= csr_wdata[LIMIT_W-1:0];
               CSR_PAGE_HOLD:      hold_ff  <= csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
         if (cmd.power) begin
            page_ff    <= page_in;
            changed_ff <= changed_in;
            if (rotate) begin
               page_start_ff <= now_ff;
            end
         end
         if (cmd.finish) begin
            energy_ff    <= energy_in;
            last_time_ff <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff <= in_current_ma;
         now_ff <= in_time_ms;
      end
      if (cmd.power) begin
         clean_ff <= clean_in;
         green_ff <= clean_in <= limit_ff;
         power_ff <= POWER_W'(clean_in) * POWER_W'(volt_ff);
         dt_ff    <= now_ff - last_time_ff;
         skip_ff  <= last_time_ff == '0;
      end
      if (cmd.energy) begin
         prod_ff <= PROD_W'(power_ff) * PROD_W'(dt_ff);
      end
      if (cmd.finish) begin
         o_clean_ff   <= clean_ff;
         o_power_ff   <= power_ff;
         o_energy_ff  <= energy_in;
         o_green_ff   <= green_ff;
         o_page_ff    <= page_ff;
         o_changed_ff <= changed_ff;
      end
   end

   assign out_clean_current_ma = o_clean_ff;
   assign out_power_mw         = o_power_ff;
   assign out_energy_uj        = o_energy_ff;
   assign out_green_on         = o_green_ff;
   assign out_red_on           = !o_green_ff;
   assign out_display_page     = o_page_ff;
   assign out_page_changed     = o_changed_ff;

   `PEM_ASSERT(a_energy_never_drops, clock, reset,
      1'b1 |=> (energy_ff >= $past(energy_ff)), "energy total decreased")
   `PEM_ASSERT(a_page_in_range, clock, reset,
      (page_ff == PAGE_POWER || page_ff == PAGE_CURRENT || page_ff == PAGE_ENERGY),
      "display page out of range")
   `PEM_ASSERT(a_page_moves_on_power_step, clock, reset,
      (!cmd.power) |=> $stable(page_ff), "page changed outside the power step")

endmodule

FILE: rtl/power_energy_meter_unit.sv
// top level of the power energy meter
//
// one request word carries an rms current sample in mA and a millisecond
// timestamp; one response word comes back for each: cleaned current, power
// in mW, the running saturating energy total, the green/red overload flags
// and the display page with a flag when this sample rotated it.
// settings (supply voltage, overload limit, noise floor, page hold time)
// are for the user to write through the csr port only while no word is in
// flight; the block itself does not enforce it. a word is captured at the
// accepting edge, then goes through the current-times-voltage multiply,
// the power-times-interval multiply and the saturating add, which loads
// the response word once the output register is free. the next request
// is taken only after that, so the block does not take a new word before
// it is through with the last one.
// the response sits in an output register; while the receiver stalls,
// the next word still runs up to the add and waits there.
// reset restores the default settings and clears the energy total, the
// previous timestamp, the page start and the page (power).

module power_energy_meter_unit
   import pem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pem_req_if.sink               req_ch,
   pem_rsp_if.source             rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;

   pem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   pem_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .in_current_ma        (req_ch.current_ma),
      .in_time_ms           (req_ch.time_ms),
      .out_clean_current_ma (rsp_ch.clean_current_ma),
      .out_power_mw         (rsp_ch.power_mw),
      .out_energy_uj        (rsp_ch.energy_uj),
      .out_green_on         (rsp_ch.green_on),
      .out_red_on           (rsp_ch.red_on),
      .out_display_page     (rsp_ch.display_page),
      .out_page_changed     (rsp_ch.page_changed)
   );

endmodule

FILE: verif/testbench.sv
// testbench of power_energy_meter_unit: directed, extreme, random, stall, saturation; scoreboard
module testbench;
   import pem_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [CUR_W-1:0]    clean;
      logic [POWER_W-1:0]  power;
      logic [ENERGY_W-1:0] energy;
      logic                green;
      logic                red;
      page_type            page;
      logic                changed;
   } meter_reading_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pem_req_if req_if ();
   pem_rsp_if rsp_if ();

   power_energy_meter_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // meter settings and state as the block should hold them
   logic [VOLT_W-1:0]   m_volt;
   logic [LIMIT_W-1:0]  m_limit;
   logic [LIMIT_W-1:0]  m_floor;
   logic [HOLD_W-1:0]   m_hold;
   logic [TIME_W-1:0]   m_last_stamp;
   logic [ENERGY_W-1:0] m_energy;
   page_type            m_page;
   logic [TIME_W-1:0]   m_page_start;

   meter_reading_type expected_readings[$];
   idle_mode_type     idle_mode;
   int                stall_cycles;
   logic [TIME_W-1:0] sample_ms;
   int                errors;
   int                samples_sent;
   int                readings_checked;
   int                red_readings;
   int                page_rotations;
   int                saturated_readings;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic page_type rotate_page(page_type cur);
      if (cur == PAGE_POWER) return PAGE_CURRENT;
      if (cur == PAGE_CURRENT) return PAGE_ENERGY;
      return PAGE_POWER;
   endfunction

   function automatic meter_reading_type meter_predict(logic [CUR_W-1:0] cur,
                                                       logic [TIME_W-1:0] stamp);
      meter_reading_type r;
      logic [TIME_W-1:0]   dt;
      logic [TIME_W-1:0]   since;
      logic [ENERGY_W:0]   sum;
      r.clean = (cur < m_floor) ? '0 : cur;
      r.green = (r.clean <= m_limit);
      r.red = !r.green;
      r.power = POWER_W'(r.clean) * POWER_W'(m_volt);
      // no energy while the previous stamp is zero
      if (m_last_stamp != '0) begin
         dt = stamp - m_last_stamp;
         sum = (ENERGY_W + 1)'(m_energy) + (ENERGY_W + 1)'(r.power) * (ENERGY_W + 1)'(dt);
         m_energy = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];
      end
      m_last_stamp = stamp;
      since = stamp - m_page_start;
      r.changed = (since >= TIME_W'(m_hold));
      if (r.changed) begin
         m_page = rotate_page(m_page);
         m_page_start = stamp;
      end
      r.energy = m_energy;
      r.page = m_page;
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 60)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_readings
      meter_reading_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none actual energy %0h", $time,
                     rsp_if.energy_uj);
         end else begin
            want = expected_readings.pop_front();
            compare_field("clean_current_ma", 64'(want.clean), 64'(rsp_if.clean_current_ma));
            compare_field("power_mw", 64'(want.power), 64'(rsp_if.power_mw));
            compare_field("energy_uj", want.energy, rsp_if.energy_uj);
            compare_field("green_on", 64'(want.green), 64'(rsp_if.green_on));
            compare_field("red_on", 64'(want.red), 64'(rsp_if.red_on));
            compare_field("display_page", 64'(want.page), 64'(rsp_if.display_page));
            compare_field("page_changed", 64'(want.changed), 64'(rsp_if.page_changed));
            readings_checked++;
            red_readings += int'(want.red);
            page_rotations += int'(want.changed);
            if (want.energy == '1) saturated_readings++;
         end
      end
   end

   // receiver side, the long hold-off is counted here
   always @(negedge clock) begin
      if (stall_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         stall_cycles--;
      end else if (idle_mode == IDLE_RECEIVER) begin
         rsp_if.ready <= ($urandom_range(99) >= 69);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_if.ready <= ($urandom_range(99) >= 9);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_sample(input logic [CUR_W-1:0] cur, input logic [TIME_W-1:0] stamp);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 69 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.current_ma <= cur;
      req_if.time_ms <= stamp;
      do @(posedge clock); while (!req_if.ready);
      expected_readings.push_back(meter_predict(cur, stamp));
      samples_sent++;
   endtask

   // stop offering words and wait until every reading is back
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_setting(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SUPPLY_VOLTAGE: m_volt = value[VOLT_W-1:0];
         CSR_OVERLOAD_LIMIT: m_limit = value[LIMIT_W-1:0];
         CSR_NOISE_FLOOR:    m_floor = value[LIMIT_W-1:0];
         default:            m_hold = value[HOLD_W-1:0];
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [TIME_W-1:0] next_stamp();
      case ($urandom_range(39))
         0: sample_ms = $urandom;
         1: sample_ms = '0;
         2: sample_ms = sample_ms - $urandom_range(2000);
         3: sample_ms = 32'hFFFF_FFFF - $urandom_range(3);
         default: sample_ms = sample_ms + $urandom_range(1500);
      endcase
      return sample_ms;
   endfunction

   function automatic logic [CUR_W-1:0] random_current();
      logic [CUR_W-1:0] cur;
      case ($urandom_range(9))
         0: cur = '0;
         1: cur = '1;
         2: cur = CUR_W'(m_floor + $urandom_range(2) - 1);
         3: cur = CUR_W'(m_limit + $urandom_range(2) - 1);
         4, 5: cur = CUR_W'($urandom_range(300));
         default: cur = CUR_W'($urandom);
      endcase
      return cur;
   endfunction

   task automatic pick_settings();
      write_setting(CSR_SUPPLY_VOLTAGE, CSR_DATA_W'($urandom));
      case ($urandom_range(3))
         0: write_setting(CSR_OVERLOAD_LIMIT, '0);
         1: write_setting(CSR_OVERLOAD_LIMIT, 16'h7FFF);
         default: write_setting(CSR_OVERLOAD_LIMIT, CSR_DATA_W'($urandom_range(6000)));
      endcase
      case ($urandom_range(5))
         0: write_setting(CSR_NOISE_FLOOR, '0);
         1: write_setting(CSR_NOISE_FLOOR, CSR_DATA_W'($urandom));
         default: write_setting(CSR_NOISE_FLOOR, CSR_DATA_W'($urandom_range(300)));
      endcase
      case ($urandom_range(4))
         0: write_setting(CSR_PAGE_HOLD, '0);
         1: write_setting(CSR_PAGE_HOLD, 16'hFFFF);
         2: write_setting(CSR_PAGE_HOLD, CSR_DATA_W'($urandom));
         default: write_setting(CSR_PAGE_HOLD, CSR_DATA_W'($urandom_range(4000)));
      endcase
   endtask

   // reset settings: first stamp after reset, floor and limit edges, wraps, page order
   task automatic test_directed();
      send_sample(15'd1000, 32'd100);
      send_sample(15'd1000, 32'd600);
      send_sample(15'd89, 32'd700);
      send_sample(15'd90, 32'd800);
      send_sample(15'd4000, 32'd1200);
      send_sample(15'd4001, 32'd3100);
      send_sample(15'h7FFF, 32'd3200);
      send_sample(15'd0, 32'd0);
      send_sample(15'd2000, 32'd50);
      send_sample(15'd2000, 32'hFFFF_FFF0);
      send_sample(15'd2000, 32'h0000_0010);
      send_sample(15'h7FFF, 32'hFFFF_FFFF);
      send_sample(15'h5555, 32'hAAAA_AAAA);
      settle();
      // zero hold rotates on every word, also with an unchanged stamp
      write_setting(CSR_PAGE_HOLD, '0);
      send_sample(15'd500, 32'd20);
      send_sample(15'd500, 32'd30);
      send_sample(15'd500, 32'd30);
      send_sample(15'd500, 32'd31);
      settle();
   endtask

   task automatic test_setting_extremes();
      write_setting(CSR_SUPPLY_VOLTAGE, 16'hFFFF);
      write_setting(CSR_OVERLOAD_LIMIT, '0);
      write_setting(CSR_NOISE_FLOOR, '0);
      write_setting(CSR_PAGE_HOLD, 16'hFFFF);
      send_sample(15'd0, 32'd1000);
      send_sample(15'd1, 32'd2000);
      send_sample(15'h7FFF, 32'd70000);
      send_sample(15'h7FFF, 32'd140000);
      settle();
      write_setting(CSR_SUPPLY_VOLTAGE, '0);
      write_setting(CSR_OVERLOAD_LIMIT, 16'hFFFF);
      write_setting(CSR_NOISE_FLOOR, 16'h7FFF);
      write_setting(CSR_PAGE_HOLD, 16'd1);
      send_sample(15'h7FFF, 32'd140001);
      send_sample(15'h7FFE, 32'd140001);
      send_sample(15'h7FFF, 32'd140005);
      settle();
   endtask

   task automatic test_random();
      idle_mode_type phase;
      for (int p = 0; p < 8; p++) begin
         phase = idle_mode_type'(p % 4);
         pick_settings();
         idle_mode = phase;
         for (int i = 0; i < 90; i++) send_sample(random_current(), next_stamp());
         settle();
      end
      idle_mode = IDLE_NONE;
   endtask

   // receiver holds off while words keep coming, so the block backs up
   task automatic test_backpressure();
      write_setting(CSR_NOISE_FLOOR, 16'd50);
      write_setting(CSR_PAGE_HOLD, 16'd700);
      stall_cycles = 300;
      for (int i = 0; i < 30; i++) send_sample(random_current(), next_stamp());
      settle();
   endtask

   // full power over backward steps pushes the total into saturation
   task automatic test_saturation();
      write_setting(CSR_SUPPLY_VOLTAGE, 16'd511);
      write_setting(CSR_NOISE_FLOOR, '0);
      idle_mode = IDLE_BOTH;
      for (int i = 0; i < 275; i++) send_sample(15'h7FFF, 32'hFFFF_FFFF - i);
      settle();
      idle_mode = IDLE_NONE;
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_SUPPLY_VOLTAGE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.current_ma = '0;
      req_if.time_ms = '0;
      rsp_if.ready = 1'b0;
      idle_mode = IDLE_NONE;
      stall_cycles = 0;
      sample_ms = 32'd5000;
      errors = 0;
      samples_sent = 0;
      readings_checked = 0;
      red_readings = 0;
      page_rotations = 0;
      saturated_readings = 0;
      m_volt = SUPPLY_VOLTAGE_RST;
      m_limit = OVERLOAD_LIMIT_RST;
      m_floor = NOISE_FLOOR_RST;
      m_hold = PAGE_HOLD_RST;
      m_last_stamp = '0;
      m_energy = '0;
      m_page = PAGE_POWER;
      m_page_start = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_setting_extremes();
      test_random();
      test_backpressure();
      test_saturation();

      $display("%0d samples sent, %0d readings checked: %0d red, %0d page turns",
               samples_sent, readings_checked, red_readings, page_rotations);
      $display("%0d readings at the saturated energy total", saturated_readings);
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d readings outstanding", expected_readings.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
